// ===== rtl/cfba_pkg.sv =====
// shared constants and controller/datapath command and status types
// for the chained free block allocator; no dependencies
`default_nettype none

package cfba_pkg;

    localparam int BLK_W           = 10;
    localparam int BLOCK_COUNT     = 1 << BLK_W;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int TDATA_W         = 16;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic accept;
        logic decide;
        logic push;
        logic pop;
        logic spill;
        logic refill;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic full;
        logic fail;
        logic last;
        logic sweep_done;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/cfba_dp.sv =====
// allocator datapath: stack memory, chain memories, count and sweep index
// depends on cfba_pkg
`default_nettype none

module cfba_dp #(
    parameter int STACK_DEPTH = cfba_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_type,
    input  wire logic [cfba_pkg::BLK_W-1:0]  i_block_number,
    input  wire cfba_pkg::t_cmd              i_cmd,
    output cfba_pkg::t_stat                  o_stat,
    output logic      [cfba_pkg::BLK_W-1:0]  o_granted_block,
    output logic                             o_status
);

    localparam int BW          = cfba_pkg::BLK_W;
    localparam int CW          = $clog2(STACK_DEPTH + 1);
    localparam int SAW         = $clog2(STACK_DEPTH);
    localparam int CHAIN_DEPTH = cfba_pkg::BLOCK_COUNT * (2 ** SAW);

    logic [BW-1:0] mem_stack [STACK_DEPTH];
    logic [BW-1:0] mem_chain [CHAIN_DEPTH];
    logic [CW-1:0] mem_cnt   [cfba_pkg::BLOCK_COUNT];

    logic          r_req;
    logic [BW-1:0] r_blk;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [BW-1:0] r_row;
    logic [BW-1:0] r_grant;
    logic          r_status;
    logic [BW-1:0] r_out_grant;
    logic          r_out_status;
    logic [BW-1:0] r_stack_rd;
    logic [BW-1:0] r_chain_rd;
    logic [CW-1:0] r_cnt_rd;

    logic           w_fail;
    logic [BW-1:0]  w_grant;
    logic [SAW-1:0] w_top_addr;
    logic [SAW-1:0] w_idx_lo;
    logic [SAW-1:0] w_idx_prev;
    logic           w_sweep_done;
    logic [SAW-1:0] w_stack_raddr;
    logic           w_stack_we;
    logic [SAW-1:0] w_stack_waddr;
    logic [BW-1:0]  w_stack_wdata;
    logic           w_chain_we;
    logic [CW-1:0]  w_refill_n;

    assign w_fail       = (r_req == cfba_pkg::REQ_ALLOC)
                          && ((r_count == '0) || (r_stack_rd == '0));
    assign w_grant      = ((r_req == cfba_pkg::REQ_ALLOC) && !w_fail) ? r_stack_rd : '0;
    assign w_top_addr   = SAW'(r_count - CW'(1));
    assign w_idx_lo     = r_idx[SAW-1:0];
    assign w_idx_prev   = SAW'(r_idx - CW'(1));
    assign w_sweep_done = (r_idx == CW'(STACK_DEPTH));
    assign w_refill_n   = (r_cnt_rd > CW'(STACK_DEPTH)) ? CW'(STACK_DEPTH) : r_cnt_rd;

    assign w_stack_raddr = i_cmd.spill ? w_idx_lo : w_top_addr;
    assign w_chain_we    = i_cmd.spill && (r_idx != '0);

    always_comb begin
        w_stack_we    = 1'b0;
        w_stack_waddr = '0;
        w_stack_wdata = r_blk;
        priority if (i_cmd.push) begin
            w_stack_we    = 1'b1;
            w_stack_waddr = SAW'(r_count);
        end else if (i_cmd.spill && w_sweep_done) begin
            w_stack_we    = 1'b1;
        end else if (i_cmd.refill && (r_idx != '0)) begin
            w_stack_we    = 1'b1;
            w_stack_waddr = w_idx_prev;
            w_stack_wdata = r_chain_rd;
        end else begin
            w_stack_we    = 1'b0;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_stack_we) begin
            mem_stack[w_stack_waddr] <= w_stack_wdata;
        end
        r_stack_rd <= mem_stack[w_stack_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_chain_we) begin
            mem_chain[{r_row, w_idx_prev}] <= r_stack_rd;
        end
        r_chain_rd <= mem_chain[{r_row, w_idx_lo}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.spill && (r_idx == '0)) begin
            mem_cnt[r_row] <= CW'(STACK_DEPTH);
        end
        r_cnt_rd <= mem_cnt[r_row];
    end

    always_comb begin
        n_count = r_count;
        priority if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.spill && w_sweep_done) begin
            n_count = CW'(1);
        end else if (i_cmd.refill && w_sweep_done) begin
            n_count = w_refill_n;
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        n_idx = r_idx;
        priority if (i_cmd.decide) begin
            n_idx = '0;
        end else if ((i_cmd.spill || i_cmd.refill) && !w_sweep_done) begin
            n_idx = r_idx + CW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_blk <= i_block_number;
        end
        if (i_cmd.decide) begin
            r_grant  <= w_grant;
            r_status <= w_fail;
            r_row    <= (r_req == cfba_pkg::REQ_FREE) ? r_blk : r_stack_rd;
        end
        if (i_cmd.load_out) begin
            r_out_grant  <= i_cmd.decide ? w_grant : r_grant;
            r_out_status <= i_cmd.decide ? w_fail : r_status;
        end
    end

    assign o_stat.is_free    = (r_req == cfba_pkg::REQ_FREE);
    assign o_stat.full       = (r_count == CW'(STACK_DEPTH));
    assign o_stat.fail       = w_fail;
    assign o_stat.last       = (r_count == CW'(1));
    assign o_stat.sweep_done = w_sweep_done;

    assign o_granted_block = r_out_grant;
    assign o_status        = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/cfba_ctrl.sv =====
// allocator controller: request sequencing, spill and refill sweeps, result handshake
// depends on cfba_pkg
`default_nettype none

module cfba_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    input  wire cfba_pkg::t_stat i_stat,
    output cfba_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOK   = 5'b00010,
        ST_SPILL  = 5'b00100,
        ST_REFILL = 5'b01000,
        ST_RESP   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.decide = 1'b1;
                priority if (i_stat.is_free && i_stat.full) begin
                    n_state = ST_SPILL;
                end else if (!i_stat.is_free && !i_stat.fail && i_stat.last) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_REFILL;
                end else begin
                    o_cmd.push = i_stat.is_free;
                    o_cmd.pop  = !i_stat.is_free && !i_stat.fail;
                    if (w_out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_SPILL: begin
                o_cmd.spill = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_REFILL: begin
                o_cmd.refill = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/chained_free_block_allocator.sv =====
// Chained free block allocator, top level; uses cfba_pkg, cfba_ctrl and cfba_dp.
// A free request pushes its block on a stack of STACK_DEPTH free block numbers;
// when the stack is full it is first copied into the chain memory row of the
// freed block and emptied. An allocate pops the top block; an empty stack or a
// zero on top reports status 1 with block 0. A pop that empties the stack
// refills it from the popped block's chain row. One request is handled at a
// time; a spill or refill copies one entry per cycle between the stack memory
// and the chain memory, each with one read port. A finished result waits in
// the output register while the next request is taken. Chain rows hold no data
// until spilled, and refilling from a block never spilled is undefined. There
// is no clearing pass after reset.
`default_nettype none

module chained_free_block_allocator #(
    parameter int STACK_DEPTH = cfba_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [cfba_pkg::TDATA_W-1:0]  s_axis_tdata,   // block_number
    input  wire logic                          s_axis_tuser,   // req_type
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [cfba_pkg::TDATA_W-1:0]  m_axis_tdata,   // granted_block
    output logic                               m_axis_tuser    // status
);

    cfba_pkg::t_cmd                w_cmd;
    cfba_pkg::t_stat               w_stat;
    logic [cfba_pkg::BLK_W-1:0]    w_grant;
    logic                          w_status;

    cfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cfba_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (s_axis_tuser),
        .i_block_number  (s_axis_tdata[cfba_pkg::BLK_W-1:0]),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_granted_block (w_grant),
        .o_status        (w_status)
    );

    assign m_axis_tdata = {{(cfba_pkg::TDATA_W - cfba_pkg::BLK_W){1'b0}}, w_grant};
    assign m_axis_tuser = w_status;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    a_spill_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.spill |-> w_stat.is_free)
        else $error("spill sweep outside a free request");

    a_refill_on_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.refill |-> !w_stat.is_free)
        else $error("refill sweep outside an allocate request");

    a_fail_grants_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == cfba_pkg::STATUS_FAIL))
            |-> (m_axis_tdata == '0))
        else $error("failed allocate carries a block number");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/allocator_checker.sv =====
`timescale 1ns / 100ps
// checker for the chained free block allocator: predicts each grant from the
// accepted requests and compares it with the result stream; uses cfba_pkg

module allocator_checker #(
    parameter int STACK_DEPTH = cfba_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_tvalid,
    input  wire logic                         i_req_tready,
    input  wire logic [cfba_pkg::TDATA_W-1:0] i_req_tdata,    // block_number
    input  wire logic                         i_req_tuser,    // req_type
    input  wire logic                         i_grant_tvalid,
    input  wire logic                         i_grant_tready,
    input  wire logic [cfba_pkg::TDATA_W-1:0] i_grant_tdata,  // granted_block
    input  wire logic                         i_grant_tuser,  // status
    output int                                o_fail_count,
    output int                                o_pending
);

    typedef struct packed {
        logic [cfba_pkg::BLK_W-1:0] block;
        logic                       status;
    } t_grant;

    logic [cfba_pkg::BLK_W-1:0] free_stack [STACK_DEPTH];
    int unsigned                free_count;
    logic [cfba_pkg::BLK_W-1:0] chain_rows [cfba_pkg::BLOCK_COUNT][STACK_DEPTH];
    int unsigned                chain_len [cfba_pkg::BLOCK_COUNT];

    t_grant expected_grants [$];
    int     fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        free_count   = 0;
    end

    function automatic t_grant predict_grant(input logic req,
                                             input logic [cfba_pkg::BLK_W-1:0] blk);
        t_grant      g;
        int unsigned n;
        int          i;
        g.block  = '0;
        g.status = cfba_pkg::STATUS_OK;
        if (req == cfba_pkg::REQ_FREE) begin
            // full stack moves into the chain row of the freed block
            if (free_count == STACK_DEPTH) begin
                chain_len[blk] = STACK_DEPTH;
                for (i = 0; i < STACK_DEPTH; i++) chain_rows[blk][i] = free_stack[i];
                free_count = 0;
            end
            free_stack[free_count] = blk;
            free_count++;
        end else if (free_count == 0 || free_stack[free_count - 1] == '0) begin
            g.status = cfba_pkg::STATUS_FAIL;
        end else begin
            g.block = free_stack[free_count - 1];
            free_count--;
            // last entry popped, reload from its chain row
            if (free_count == 0) begin
                n = chain_len[g.block];
                if (n > STACK_DEPTH) n = STACK_DEPTH;
                for (i = 0; i < n; i++) free_stack[i] = chain_rows[g.block][i];
                free_count = n;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            expected_grants.delete();
            free_count = 0;
            o_pending <= 0;
        end else begin
            if (i_grant_tvalid && i_grant_tready) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t unexpected transfer: granted_block %0d status %0d",
                             $time, i_grant_tdata, i_grant_tuser);
                    fail_total++;
                end else begin
                    want = expected_grants.pop_front();
                    if (i_grant_tdata !== cfba_pkg::TDATA_W'(want.block)) begin
                        $display("%0t granted_block expected %0d actual %0d",
                                 $time, want.block, i_grant_tdata);
                        fail_total++;
                    end
                    if (i_grant_tuser !== want.status) begin
                        $display("%0t status expected %0d actual %0d",
                                 $time, want.status, i_grant_tuser);
                        fail_total++;
                    end
                end
            end
            if (i_req_tvalid && i_req_tready)
                expected_grants.push_back(
                    predict_grant(i_req_tuser, i_req_tdata[cfba_pkg::BLK_W-1:0]));
            o_pending <= expected_grants.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// top of the allocator testbench: clock, reset, request and grant stream
// driving, verdict; uses cfba_pkg, chained_free_block_allocator, allocator_checker

module testbench;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [cfba_pkg::TDATA_W-1:0] s_axis_tdata = '0;   // block_number
    logic                         s_axis_tuser = 1'b0; // req_type
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [cfba_pkg::TDATA_W-1:0] m_axis_tdata;        // granted_block
    logic                         m_axis_tuser;        // status

    int fail_count;
    int pending_count;
    int burst_left = 0;

    chained_free_block_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    allocator_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_tvalid   (s_axis_tvalid),
        .i_req_tready   (s_axis_tready),
        .i_req_tdata    (s_axis_tdata),
        .i_req_tuser    (s_axis_tuser),
        .i_grant_tvalid (m_axis_tvalid),
        .i_grant_tready (m_axis_tready),
        .i_grant_tdata  (m_axis_tdata),
        .i_grant_tuser  (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_request(input logic req, input logic [cfba_pkg::BLK_W-1:0] blk);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= cfba_pkg::TDATA_W'(blk);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_grants();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // grant side: random stall patterns with a long hold-off now and then
    initial begin
        int mode;
        int span;
        int seg;
        seg = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (seg % 150 == 20) begin
                m_axis_tready <= 1'b0;
                repeat (150) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(1, 40);
                repeat (span) begin
                    case (mode)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
            seg++;
        end
    end

    initial begin
        int                         item;
        int                         seg_left;
        int                         free_pct;
        logic [cfba_pkg::BLK_W-1:0] blk;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack, then sentinel on top
        send_request(cfba_pkg::REQ_ALLOC, '1);
        send_request(cfba_pkg::REQ_FREE, '0);
        send_request(cfba_pkg::REQ_ALLOC, '1);
        // fill the stack, spill it, then pop the spill block to reload
        send_request(cfba_pkg::REQ_FREE, 10'd1023);
        send_request(cfba_pkg::REQ_FREE, 10'h155);
        send_request(cfba_pkg::REQ_FREE, 10'h2aa);
        repeat (12) send_request(cfba_pkg::REQ_FREE,
                                 cfba_pkg::BLK_W'($urandom_range(1, 1022)));
        send_request(cfba_pkg::REQ_FREE, 10'd512);
        repeat (3) send_request(cfba_pkg::REQ_ALLOC,
                                cfba_pkg::BLK_W'($urandom_range(0, 1023)));
        drain_grants();

        seg_left = 0;
        free_pct = 50;
        for (item = 0; item < 1400; item++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                free_pct = ($urandom_range(0, 1) == 1) ? 75 : 25;
            end
            seg_left--;
            if (item == 700) drain_grants();
            blk = cfba_pkg::BLK_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 19) == 0) blk = '0;
            send_request(($urandom_range(0, 99) < free_pct) ? cfba_pkg::REQ_FREE
                                                              : cfba_pkg::REQ_ALLOC, blk);
        end

        drain_grants();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cfba_pkg.sv
rtl/cfba_dp.sv
rtl/cfba_ctrl.sv
rtl/chained_free_block_allocator.sv
tb/sv/allocator_checker.sv
tb/sv/testbench.sv
